FILE: hw/rtl/abd_pkg.sv
package abd_pkg;

   localparam int NET_SIZE_MAX_DEF    = 1024;
   localparam int EXP_TABLE_DEPTH_DEF = 256;
   localparam int NET_SIZE_MIN        = 64;
   localparam int QUOT_W              = 20;   // prior quotient bits, covers 512*65536/64
   localparam int EXP_W               = 20;   // exp table entry, unsigned Q4.16

   // configuration register indexes
   localparam logic [2:0] REG_THRESHOLD    = 3'd0;
   localparam logic [2:0] REG_NET_WIDTH    = 3'd1;
   localparam logic [2:0] REG_NET_HEIGHT   = 3'd2;
   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd3;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;
   localparam logic [2:0] REG_LAYOUT_MODE  = 3'd5;

   // prior divisions
   localparam logic [1:0] DIV_CX = 2'd0;
   localparam logic [1:0] DIV_CY = 2'd1;
   localparam logic [1:0] DIV_PW = 2'd2;
   localparam logic [1:0] DIV_PH = 2'd3;

   // multiply steps: DX..BH issue one product each, DY..FIN retire the previous one
   localparam logic [3:0] STEP_DX  = 4'd0;
   localparam logic [3:0] STEP_DY  = 4'd1;
   localparam logic [3:0] STEP_EW  = 4'd2;
   localparam logic [3:0] STEP_EH  = 4'd3;
   localparam logic [3:0] STEP_L   = 4'd4;
   localparam logic [3:0] STEP_T   = 4'd5;
   localparam logic [3:0] STEP_BW  = 4'd6;
   localparam logic [3:0] STEP_BH  = 4'd7;
   localparam logic [3:0] STEP_FIN = 4'd8;

   typedef struct packed {
      logic [15:0]        anchor_score;
      logic signed [15:0] delta_x;
      logic signed [15:0] delta_y;
      logic signed [15:0] delta_w;
      logic signed [15:0] delta_h;
   } req_payload_type;

   typedef struct packed {
      logic               keep;
      logic signed [19:0] box_left;
      logic signed [19:0] box_top;
      logic [18:0]        box_width;
      logic [18:0]        box_height;
      logic [15:0]        score_out;
      logic [15:0]        anchor_index;
      logic               last_anchor;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] score_threshold;
      logic [10:0] net_width;
      logic [10:0] net_height;
      logic [13:0] image_width;
      logic [13:0] image_height;
      logic        layout_mode;
   } cfg_type;

   typedef struct packed {
      logic       capture;
      logic       div_start;
      logic       div_store;
      logic [1:0] div_sel;
      logic       mul_en;
      logic [3:0] mul_step;
      logic       out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic keep;
      logic div_done;
   } ctrl_status_type;

   function automatic logic [2:0] levels_of(input logic mode);
      return mode ? 3'd3 : 3'd4;
   endfunction

   function automatic logic [1:0] boxes_of(input logic mode, input logic [1:0] lvl);
      logic [1:0] n;
      unique case ({mode, lvl})
         3'b000:  n = 2'd3;
         3'b001:  n = 2'd2;
         3'b010:  n = 2'd2;
         3'b011:  n = 2'd3;
         3'b100:  n = 2'd2;
         3'b101:  n = 2'd2;
         3'b110:  n = 2'd2;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [9:0] side_of(input logic mode, input logic [1:0] lvl,
                                          input logic [1:0] k);
      logic [9:0] s;
      unique case ({mode, lvl, k})
         5'b00000: s = 10'd10;
         5'b00001: s = 10'd16;
         5'b00010: s = 10'd24;
         5'b00100: s = 10'd32;
         5'b00101: s = 10'd48;
         5'b01000: s = 10'd64;
         5'b01001: s = 10'd96;
         5'b01100: s = 10'd128;
         5'b01101: s = 10'd192;
         5'b01110: s = 10'd256;
         5'b10000: s = 10'd16;
         5'b10001: s = 10'd32;
         5'b10100: s = 10'd64;
         5'b10101: s = 10'd128;
         5'b11000: s = 10'd256;
         5'b11001: s = 10'd512;
         default:  s = 10'd0;
      endcase
      return s;
   endfunction

   // long division for table construction at elaboration
   function automatic longint unsigned const_div(input longint unsigned n,
                                                 input longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r    = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(0.2*x) at the centre of bucket j, Taylor series in Q28
   function automatic logic [EXP_W-1:0] exp_entry(input int j, input int depth);
      longint            num;
      longint unsigned   mag;
      longint unsigned   den;
      longint unsigned   a;
      longint unsigned   sum;
      longint unsigned   term;
      num  = 16 * (2 * longint'(j) + 1) - 16 * longint'(depth);
      mag  = longint'(num < 0 ? -num : num);
      den  = 64'd10 * longint'(depth);
      a    = const_div((mag << 28) + (den >> 1), den);
      sum  = 64'd1 << 28;
      term = 64'd1 << 28;
      for (int n = 1; n <= 24; n++) begin
         term = const_div((term * a) >> 28, longint'(n));
         sum  = sum + term;
      end
      if (num >= 0)
         return EXP_W'((sum + 64'd2048) >> 12);
      else
         return EXP_W'(const_div((64'd1 << 44) + (sum >> 1), sum));
   endfunction

endpackage

FILE: hw/rtl/anchor_box_decoder_core.sv
// Anchor box decoder. One transfer on the req_ channel carries one anchor's score and
// four box deltas, in prior order; the block tracks level, row, column and box counters
// itself and returns exactly one transfer on the rsp_ channel per anchor, in order.
// Kept anchors (score above threshold) get a box in 1/16 pixel; others return zero box
// fields with score, anchor index and last-anchor flag still valid.
// A rejected anchor goes from capture through ST_DIV to ST_OUT, which loads the result
// register and raises rsp_valid; the next anchor can then transfer. A kept one runs the
// shared restoring divider four times for the prior centre and size (start, quotient
// bits, store), then nine steps of one shared multiplier. One anchor is in flight at a
// time; req_stall is high while it is worked. The result sits in an output register,
// so the next anchor is taken while rsp_stall holds the previous result; rsp_payload
// does not change while stalled. Configuration writes (csr_, always ready) take effect
// at once; the user must make them while idle, which the block does not enforce. Reset
// (synchronous) restores the register defaults and restarts the counters at the first
// anchor of the layout; a counter set outside the configured layout also restarts.
module anchor_box_decoder_core #(
   parameter int NET_SIZE_MAX    = abd_pkg::NET_SIZE_MAX_DEF,
   parameter int EXP_TABLE_DEPTH = abd_pkg::EXP_TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  abd_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output abd_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [15:0]              csr_data
);

   abd_pkg::cfg_type         cfg_ff;
   abd_pkg::ctrl_cmd_type    cmd;
   abd_pkg::ctrl_status_type status;

   // register file: always ready, unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_threshold <= 16'd45875;
         cfg_ff.net_width       <= 11'd320;
         cfg_ff.net_height      <= 11'd240;
         cfg_ff.image_width     <= 14'd640;
         cfg_ff.image_height    <= 14'd480;
         cfg_ff.layout_mode     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            abd_pkg::REG_THRESHOLD:    cfg_ff.score_threshold <= csr_data;
            abd_pkg::REG_NET_WIDTH:    cfg_ff.net_width       <= csr_data[10:0];
            abd_pkg::REG_NET_HEIGHT:   cfg_ff.net_height      <= csr_data[10:0];
            abd_pkg::REG_IMAGE_WIDTH:  cfg_ff.image_width     <= csr_data[13:0];
            abd_pkg::REG_IMAGE_HEIGHT: cfg_ff.image_height    <= csr_data[13:0];
            abd_pkg::REG_LAYOUT_MODE:  cfg_ff.layout_mode     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // sequencer: capture, four divisions and multiply steps for kept anchors, result load
   abd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // prior generation, exp lookup, decode arithmetic and result register
   abd_dpath #(
      .NET_SIZE_MAX    (NET_SIZE_MAX),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: hw/rtl/abd_div.sv
module abd_div #(
   parameter int AW = 30,
   parameter int BW = 12,
   parameter int QW = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [AW-1:0] dividend,
   input  logic [BW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   localparam int NW = $clog2(QW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [BW-1:0] rem_ff, rem_in;
   logic [BW-1:0] den_ff, den_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [BW:0]   trial;
   logic          ge;

   // restoring division: dividend bits leave the top of quo_ff, quotient bits enter below
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = NW'(QW - 1);
         rem_in  = BW'(dividend[AW-1:QW]);
         den_in  = divisor;
         quo_in  = dividend[QW-1:0];
      end else if (busy_ff) begin
         rem_in = ge ? BW'(trial - {1'b0, den_ff}) : BW'(trial);
         quo_in = {quo_ff[QW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hw/rtl/abd_dpath.sv
module abd_dpath #(
   parameter int NET_SIZE_MAX    = abd_pkg::NET_SIZE_MAX_DEF,
   parameter int EXP_TABLE_DEPTH = abd_pkg::EXP_TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  abd_pkg::cfg_type         cfg,
   input  abd_pkg::ctrl_cmd_type    cmd,
   output abd_pkg::ctrl_status_type status,
   input  abd_pkg::req_payload_type req_payload,
   output abd_pkg::rsp_payload_type rsp_payload
);

   localparam int NW  = $clog2(NET_SIZE_MAX + 1);
   localparam int CW  = NW - 2;
   localparam int XW  = (NW + 2 > 10) ? NW + 2 : 10;
   localparam int AW  = XW + 17;
   localparam int BW  = NW + 1;
   localparam int QW  = abd_pkg::QUOT_W;
   localparam int EW  = abd_pkg::EXP_W;
   localparam int IW  = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
   localparam logic [21:0] RECIP5 = 22'd3355444;   // ceil(2^24 / 5)

   function automatic logic [NW-1:0] clamp_net(input logic [10:0] v);
      if (v < 11'(abd_pkg::NET_SIZE_MIN))
         return NW'(abd_pkg::NET_SIZE_MIN);
      else if (int'(v) > NET_SIZE_MAX)
         return NW'(NET_SIZE_MAX);
      else
         return NW'(v);
   endfunction

   function automatic logic [CW:0] grid_cells(input logic [NW-1:0] n, input logic [1:0] l);
      logic [NW:0] sum;
      sum = (NW+1)'(n) + ((NW+1)'(8) << l) - (NW+1)'(1);
      return (CW+1)'(sum >> (3 + l));
   endfunction

   function automatic logic [IW-1:0] exp_index(input logic [15:0] d);
      logic [15+IW:0] p;
      p = (16+IW)'({~d[15], d[14:0]}) * (16+IW)'(EXP_TABLE_DEPTH);
      return p[15+IW:16];
   endfunction

   // floor((p + 20480) / 40960): shift by 8192, then reciprocal of 5 on an offset value
   function automatic logic signed [19:0] offset_div(input logic signed [39:0] p);
      logic signed [39:0] t;
      logic [19:0]        v;
      logic [21:0]        u;
      logic [43:0]        m;
      logic [19:0]        q;
      t = p + 40'sd20480;
      v = t[32:13];
      u = {{2{v[19]}}, v} + 22'd2621440;
      m = 44'(u) * 44'(RECIP5);
      q = m[43:24];
      return $signed(q - 20'h80000);
   endfunction

   function automatic logic [19:0] sat_edge(input logic signed [39:0] p);
      logic signed [39:0] t;
      t = (p + 40'sd4096) >>> 13;
      if (t > 40'sd524287)
         return 20'h7FFFF;
      else if (t < -40'sd524288)
         return 20'h80000;
      else
         return t[19:0];
   endfunction

   function automatic logic [18:0] sat_size(input logic signed [39:0] p);
      logic signed [39:0] t;
      t = (p + 40'sd2048) >>> 12;
      if (t < 40'sd0)
         return 19'd0;
      else if (t > 40'sd524287)
         return 19'h7FFFF;
      else
         return t[18:0];
   endfunction

   logic [NW-1:0] wc, hc;
   logic          mode;

   assign wc   = clamp_net(cfg.net_width);
   assign hc   = clamp_net(cfg.net_height);
   assign mode = cfg.layout_mode;

   // exp table, built at elaboration
   logic [EW-1:0] exp_rom [EXP_TABLE_DEPTH];
   for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp_rom
      assign exp_rom[g] = abd_pkg::exp_entry(g, EXP_TABLE_DEPTH);
   end

   // prior counters
   logic [1:0]    lvl_ff;
   logic [CW-1:0] row_ff, col_ff;
   logic [1:0]    box_ff;
   logic [15:0]   anchor_ff;

   logic [CW:0]   cols, rows;
   logic          stale;
   logic [1:0]    nbox;
   logic [1:0]    box_inc;
   logic [CW:0]   col_inc, row_inc;
   logic [2:0]    lvl_inc;
   logic          last_w;
   logic [1:0]    lvl_in;
   logic [CW-1:0] row_in, col_in;
   logic [1:0]    box_in;

   assign cols  = grid_cells(wc, lvl_ff);
   assign rows  = grid_cells(hc, lvl_ff);
   assign nbox  = abd_pkg::boxes_of(mode, lvl_ff);
   assign stale = ({1'b0, lvl_ff} >= abd_pkg::levels_of(mode)) || (box_ff >= nbox) ||
                  ((CW+1)'(row_ff) >= rows) || ((CW+1)'(col_ff) >= cols);

   assign box_inc = box_ff + 2'd1;
   assign col_inc = (CW+1)'(col_ff) + (CW+1)'(1);
   assign row_inc = (CW+1)'(row_ff) + (CW+1)'(1);
   assign lvl_inc = {1'b0, lvl_ff} + 3'd1;

   always_comb begin
      lvl_in = lvl_ff;
      row_in = row_ff;
      col_in = col_ff;
      box_in = box_inc;
      last_w = 1'b0;
      if (box_inc >= nbox) begin
         box_in = 2'd0;
         col_in = col_inc[CW-1:0];
         if (col_inc >= cols) begin
            col_in = '0;
            row_in = row_inc[CW-1:0];
            if (row_inc >= rows) begin
               row_in = '0;
               lvl_in = lvl_inc[1:0];
               if (lvl_inc >= abd_pkg::levels_of(mode)) begin
                  lvl_in = 2'd0;
                  last_w = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff    <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         box_ff    <= '0;
         anchor_ff <= '0;
      end else if (cmd.capture && stale) begin
         lvl_ff    <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         box_ff    <= '0;
         anchor_ff <= '0;
      end else if (cmd.out_load) begin
         lvl_ff    <= lvl_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         box_ff    <= box_in;
         anchor_ff <= last_w ? 16'd0 : anchor_ff + 16'd1;
      end
   end

   // item capture
   logic          keep_ff;
   logic [15:0]   score_ff;
   logic [15:0]   dx_ff, dy_ff;
   logic [EW-1:0] exp_w_ff, exp_h_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         keep_ff  <= req_payload.anchor_score > cfg.score_threshold;
         score_ff <= req_payload.anchor_score;
         dx_ff    <= req_payload.delta_x;
         dy_ff    <= req_payload.delta_y;
         exp_w_ff <= exp_rom[exp_index(req_payload.delta_w)];
         exp_h_ff <= exp_rom[exp_index(req_payload.delta_h)];
      end
   end

   // prior divisions: quotient = floor(A / B), rounding folded into A
   logic [XW-1:0] xc_col, xc_row, side_x;
   logic [AW-1:0] div_a;
   logic [BW-1:0] div_b;
   logic          div_done;
   logic [QW-1:0] div_q;
   logic [16:0]   q_sat;
   logic [16:0]   pcx_ff, pcy_ff, pw_ff, ph_ff;

   assign xc_col = XW'({col_ff, 1'b1}) << (3 + lvl_ff);
   assign xc_row = XW'({row_ff, 1'b1}) << (3 + lvl_ff);
   assign side_x = XW'(abd_pkg::side_of(mode, lvl_ff, box_ff));

   always_comb begin
      unique case (cmd.div_sel)
         abd_pkg::DIV_CX: begin
            div_a = AW'({xc_col, 16'(wc)});
            div_b = {wc, 1'b0};
         end
         abd_pkg::DIV_CY: begin
            div_a = AW'({xc_row, 16'(hc)});
            div_b = {hc, 1'b0};
         end
         abd_pkg::DIV_PW: begin
            div_a = {side_x, 17'(wc)};
            div_b = {wc, 1'b0};
         end
         default: begin
            div_a = {side_x, 17'(hc)};
            div_b = {hc, 1'b0};
         end
      endcase
   end

   abd_div #(
      .AW (AW),
      .BW (BW),
      .QW (QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   assign q_sat = (div_q > QW'(17'h10000)) ? 17'h10000 : div_q[16:0];

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         unique case (cmd.div_sel)
            abd_pkg::DIV_CX: pcx_ff <= q_sat;
            abd_pkg::DIV_CY: pcy_ff <= q_sat;
            abd_pkg::DIV_PW: pw_ff  <= q_sat;
            default:         ph_ff  <= q_sat;
         endcase
      end
   end

   // shared multiplier
   logic signed [21:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [39:0] prod_ff;
   logic signed [19:0] cx_ff, cy_ff;
   logic [19:0]        w_ff, h_ff;
   logic [19:0]        left_ff, top_ff;
   logic [18:0]        bw_ff, bh_ff;
   logic signed [21:0] diff_x, diff_y;
   logic signed [39:0] prod_r;

   assign diff_x = $signed({cx_ff[19], cx_ff, 1'b0}) - $signed({2'b00, w_ff});
   assign diff_y = $signed({cy_ff[19], cy_ff, 1'b0}) - $signed({2'b00, h_ff});
   assign prod_r = prod_ff + 40'sd32768;

   always_comb begin
      case (cmd.mul_step)
         abd_pkg::STEP_DX: begin
            mul_a = {{6{dx_ff[15]}}, dx_ff};
            mul_b = {1'b0, pw_ff};
         end
         abd_pkg::STEP_DY: begin
            mul_a = {{6{dy_ff[15]}}, dy_ff};
            mul_b = {1'b0, ph_ff};
         end
         abd_pkg::STEP_EW: begin
            mul_a = {2'b00, exp_w_ff};
            mul_b = {1'b0, pw_ff};
         end
         abd_pkg::STEP_EH: begin
            mul_a = {2'b00, exp_h_ff};
            mul_b = {1'b0, ph_ff};
         end
         abd_pkg::STEP_L: begin
            mul_a = diff_x;
            mul_b = {4'b0000, cfg.image_width};
         end
         abd_pkg::STEP_T: begin
            mul_a = diff_y;
            mul_b = {4'b0000, cfg.image_height};
         end
         abd_pkg::STEP_BW: begin
            mul_a = {2'b00, w_ff};
            mul_b = {4'b0000, cfg.image_width};
         end
         abd_pkg::STEP_BH: begin
            mul_a = {2'b00, h_ff};
            mul_b = {4'b0000, cfg.image_height};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
         case (cmd.mul_step)
            abd_pkg::STEP_DY:  cx_ff   <= $signed({3'b000, pcx_ff}) + offset_div(prod_ff);
            abd_pkg::STEP_EW:  cy_ff   <= $signed({3'b000, pcy_ff}) + offset_div(prod_ff);
            abd_pkg::STEP_EH:  w_ff    <= prod_r[35:16];
            abd_pkg::STEP_L:   h_ff    <= prod_r[35:16];
            abd_pkg::STEP_T:   left_ff <= sat_edge(prod_ff);
            abd_pkg::STEP_BW:  top_ff  <= sat_edge(prod_ff);
            abd_pkg::STEP_BH:  bw_ff   <= sat_size(prod_ff);
            abd_pkg::STEP_FIN: bh_ff   <= sat_size(prod_ff);
            default: ;
         endcase
      end
   end

   // result register
   abd_pkg::rsp_payload_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.keep         <= keep_ff;
         rsp_ff.box_left     <= keep_ff ? left_ff : 20'd0;
         rsp_ff.box_top      <= keep_ff ? top_ff  : 20'd0;
         rsp_ff.box_width    <= keep_ff ? bw_ff   : 19'd0;
         rsp_ff.box_height   <= keep_ff ? bh_ff   : 19'd0;
         rsp_ff.score_out    <= score_ff;
         rsp_ff.anchor_index <= anchor_ff;
         rsp_ff.last_anchor  <= last_w;
      end
   end

   assign rsp_payload     = rsp_ff;
   assign status.keep     = keep_ff;
   assign status.div_done = div_done;

endmodule

FILE: hw/rtl/abd_ctrl.sv
module abd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  abd_pkg::ctrl_status_type status,
   output abd_pkg::ctrl_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       started_ff, started_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = state_ff != ST_IDLE;

   always_comb begin
      cmd          = '0;
      cmd.div_sel  = step_ff[1:0];
      state_in     = state_ff;
      step_in      = step_ff;
      started_in   = started_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DIV;
               step_in     = 4'd0;
               started_in  = 1'b0;
            end
         end
         ST_DIV: begin
            if (!status.keep) begin
               state_in = ST_OUT;
            end else if (!started_ff) begin
               cmd.div_start = 1'b1;
               started_in    = 1'b1;
            end else if (status.div_done) begin
               cmd.div_store = 1'b1;
               started_in    = 1'b0;
               if (step_ff[1:0] == abd_pkg::DIV_PH) begin
                  state_in = ST_MUL;
                  step_in  = abd_pkg::STEP_DX;
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = step_ff;
            if (step_ff == abd_pkg::STEP_FIN)
               state_in = ST_OUT;
            else
               step_in = step_ff + 4'd1;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: tb/sv/anchor_box_checker.sv
`timescale 1ns / 1ps

module anchor_box_checker
   import abd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [2:0]      csr_index,
   input  logic [15:0]     csr_data,
   output int              fail_count,
   output int              pending,
   output int              kept_count,
   output int              frame_count
);

   localparam int EXP_DEPTH = EXP_TABLE_DEPTH_DEF;
   localparam int NET_MAX   = NET_SIZE_MAX_DEF;

   cfg_type         cfg;
   int unsigned     lvl, row, col, bsz;
   logic [15:0]     anchor_num;
   longint unsigned exp_q16 [EXP_DEPTH];
   rsp_payload_type boxes_due [$];

   function automatic longint round_div(longint n, longint d);
      longint a;
      longint b;
      longint q;
      a = 2 * n + d;
      b = 2 * d;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int unsigned level_count(logic mode);
      return mode ? 3 : 4;
   endfunction

   function automatic int unsigned box_count(logic mode, int unsigned l);
      if (mode) return (l < 3) ? 2 : 0;
      return (l == 0 || l == 3) ? 3 : 2;
   endfunction

   function automatic longint box_side(logic mode, int unsigned l, int unsigned k);
      if (mode) return longint'(16) << (2 * l + k);   // 16,32 / 64,128 / 256,512
      case (l)
         0:       return (k == 0) ? 10 : ((k == 1) ? 16 : 24);
         1:       return (k == 0) ? 32 : 48;
         2:       return (k == 0) ? 64 : 96;
         default: return longint'(128) + 64 * k;
      endcase
   endfunction

   function automatic int unsigned net_clamp(logic [10:0] v);
      if (v < 64) return 64;
      if (v > NET_MAX) return NET_MAX;
      return v;
   endfunction

   // exp(0.2*x) per bucket, Taylor series in Q28, kept as Q16
   function automatic void build_exp();
      longint          num;
      longint unsigned mag, den, a, sum, term;
      for (int j = 0; j < EXP_DEPTH; j++) begin
         num  = 16 * (2 * longint'(j) + 1) - 16 * EXP_DEPTH;
         mag  = (num < 0) ? -num : num;
         den  = 10 * EXP_DEPTH;
         a    = ((mag << 28) + den / 2) / den;
         sum  = 64'd1 << 28;
         term = 64'd1 << 28;
         for (int n = 1; n <= 24; n++) begin
            term = ((term * a) >> 28) / n;
            sum  = sum + term;
         end
         exp_q16[j] = (num >= 0) ? ((sum + 2048) >> 12) : (((64'd1 << 44) + sum / 2) / sum);
      end
   endfunction

   function automatic void reset_model();
      cfg        = '{score_threshold: 16'd45875, net_width: 11'd320, net_height: 11'd240,
                     image_width: 14'd640, image_height: 14'd480, layout_mode: 1'b0};
      lvl        = 0;
      row        = 0;
      col        = 0;
      bsz        = 0;
      anchor_num = '0;
   endfunction

   function automatic void decode_anchor(req_payload_type p);
      rsp_payload_type r;
      int unsigned     w_net, h_net, stride, cols, rows;
      longint          pcx, pcy, pw, ph, side, cx, cy, bw, bh, dw, dh;
      logic            frame_end;
      w_net = net_clamp(cfg.net_width);
      h_net = net_clamp(cfg.net_height);
      // counters outside the current layout restart the frame
      if (lvl >= level_count(cfg.layout_mode) || bsz >= box_count(cfg.layout_mode, lvl) ||
          row >= (h_net + (8 << lvl) - 1) / (8 << lvl) ||
          col >= (w_net + (8 << lvl) - 1) / (8 << lvl)) begin
         lvl = 0; row = 0; col = 0; bsz = 0; anchor_num = '0;
      end
      stride = 8 << lvl;
      cols   = (w_net + stride - 1) / stride;
      rows   = (h_net + stride - 1) / stride;
      side   = box_side(cfg.layout_mode, lvl, bsz);
      pcx = clip(round_div((2 * longint'(col) + 1) * stride * 65536, 2 * w_net), 0, 65536);
      pcy = clip(round_div((2 * longint'(row) + 1) * stride * 65536, 2 * h_net), 0, 65536);
      pw  = clip(round_div(side * 65536, w_net), 0, 65536);
      ph  = clip(round_div(side * 65536, h_net), 0, 65536);
      r = '0;
      r.keep = p.anchor_score > cfg.score_threshold;
      if (r.keep) begin
         cx = pcx + round_div(longint'($signed(p.delta_x)) * pw, 40960);
         cy = pcy + round_div(longint'($signed(p.delta_y)) * ph, 40960);
         dw = exp_q16[((longint'($signed(p.delta_w)) + 32768) * EXP_DEPTH) >> 16];
         dh = exp_q16[((longint'($signed(p.delta_h)) + 32768) * EXP_DEPTH) >> 16];
         bw = round_div(dw * pw, 65536);
         bh = round_div(dh * ph, 65536);
         r.box_left   = clip(round_div((2 * cx - bw) * cfg.image_width, 8192), -524288, 524287);
         r.box_top    = clip(round_div((2 * cy - bh) * cfg.image_height, 8192), -524288, 524287);
         r.box_width  = clip(round_div(bw * cfg.image_width, 4096), 0, 524287);
         r.box_height = clip(round_div(bh * cfg.image_height, 4096), 0, 524287);
      end
      r.score_out    = p.anchor_score;
      r.anchor_index = anchor_num;
      frame_end = 1'b0;
      bsz++;
      if (bsz >= box_count(cfg.layout_mode, lvl)) begin
         bsz = 0;
         col++;
         if (col >= cols) begin
            col = 0;
            row++;
            if (row >= rows) begin
               row = 0;
               lvl++;
               if (lvl >= level_count(cfg.layout_mode)) begin
                  lvl       = 0;
                  frame_end = 1'b1;
               end
            end
         end
      end
      anchor_num    = frame_end ? 16'd0 : anchor_num + 16'd1;
      r.last_anchor = frame_end;
      boxes_due     = {boxes_due, r};
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("%0t: mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count  = 0;
      kept_count  = 0;
      frame_count = 0;
      pending     = 0;
      build_exp();
      reset_model();
   end

   rsp_payload_type want;

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         boxes_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_THRESHOLD:    cfg.score_threshold = csr_data;
               REG_NET_WIDTH:    cfg.net_width       = csr_data[10:0];
               REG_NET_HEIGHT:   cfg.net_height      = csr_data[10:0];
               REG_IMAGE_WIDTH:  cfg.image_width     = csr_data[13:0];
               REG_IMAGE_HEIGHT: cfg.image_height    = csr_data[13:0];
               REG_LAYOUT_MODE:  cfg.layout_mode     = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) decode_anchor(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (boxes_due.size() == 0) begin
               report("unexpected transfer, anchor_index", rsp_payload.anchor_index, -1);
            end else begin
               want = boxes_due.pop_front();
               if (want.keep) kept_count++;
               if (want.last_anchor) frame_count++;
               if (rsp_payload.keep !== want.keep)
                  report("keep", rsp_payload.keep, want.keep);
               if (rsp_payload.box_left !== want.box_left)
                  report("box_left", rsp_payload.box_left, want.box_left);
               if (rsp_payload.box_top !== want.box_top)
                  report("box_top", rsp_payload.box_top, want.box_top);
               if (rsp_payload.box_width !== want.box_width)
                  report("box_width", rsp_payload.box_width, want.box_width);
               if (rsp_payload.box_height !== want.box_height)
                  report("box_height", rsp_payload.box_height, want.box_height);
               if (rsp_payload.score_out !== want.score_out)
                  report("score_out", rsp_payload.score_out, want.score_out);
               if (rsp_payload.anchor_index !== want.anchor_index)
                  report("anchor_index", rsp_payload.anchor_index, want.anchor_index);
               if (rsp_payload.last_anchor !== want.last_anchor)
                  report("last_anchor", rsp_payload.last_anchor, want.last_anchor);
            end
         end
      end
      pending = boxes_due.size();
   end

endmodule

FILE: tb/sv/tb_anchor_box_decoder_core.sv
`timescale 1ns / 1ps

module tb_anchor_box_decoder_core;
   import abd_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 95;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [2:0]      csr_index = '0;
   logic [15:0]     csr_data = '0;

   int fail_count, pending, kept_count, frame_count;
   int items_sent = 0;
   int cycles = 0;
   bit quiet = 0;         // no idling on either side
   bit long_hold = 0;     // receiver holds off for a long stretch
   logic [15:0] threshold_now = 16'd45875;

   anchor_box_decoder_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   anchor_box_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending), .kept_count(kept_count),
      .frame_count(frame_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off counted here
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 21);
         end
      end
   end

   // one csr transfer; valid drops for a cycle after each one
   task automatic csr_write(logic [2:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_THRESHOLD) threshold_now = value;
      @(posedge clock);
   endtask

   // a random gap, then hold the anchor until the transfer
   task automatic send_anchor(req_payload_type p);
      while (!quiet && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_delta();
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'(int'($urandom_range(8192)) - 4096);
         3:       return 16'(int'($urandom_range(1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_payload_type random_anchor();
      req_payload_type p;
      p.anchor_score = ($urandom_range(1)) ? 16'($urandom_range(65535, threshold_now))
                                          : 16'($urandom);
      p.delta_x = pick_delta();
      p.delta_y = pick_delta();
      p.delta_w = pick_delta();
      p.delta_h = pick_delta();
      return p;
   endfunction

   // network size: mostly small so frames complete, sometimes extremes
   function automatic logic [15:0] pick_net();
      case ($urandom_range(9))
         0:       return 16'd1024;
         1:       return 16'($urandom_range(63));        // clamps up
         2:       return 16'($urandom_range(2047, 1025)); // clamps down
         default: return 16'($urandom_range(100, 64));
      endcase
   endfunction

   function automatic logic [15:0] pick_image();
      case ($urandom_range(7))
         0:       return 16'd0;
         1:       return 16'd8192;
         2:       return 16'h3fff;
         default: return 16'($urandom_range(8192, 1));
      endcase
   endfunction

   req_payload_type d;

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, score around threshold, delta extremes
      d = '{16'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};       send_anchor(d);
      d = '{16'd45875, 16'h0000, 16'h0000, 16'h0000, 16'h0000};   send_anchor(d);
      d = '{16'd45876, 16'h0000, 16'h0000, 16'h0000, 16'h0000};   send_anchor(d);
      d = '{16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};    send_anchor(d);
      d = '{16'hffff, 16'h8000, 16'h8000, 16'h8000, 16'h8000};    send_anchor(d);
      d = '{16'hffff, 16'hffff, 16'h0001, 16'hffff, 16'h0001};    send_anchor(d);
      d = '{16'hffff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000};    send_anchor(d);
      go_idle();
      // unknown indexes are ignored; then out-of-range net sizes and
      // a layout switch made mid-frame
      csr_write(3'd6, 16'hffff);
      csr_write(3'd7, 16'h0000);
      csr_write(REG_THRESHOLD, 16'd0);
      csr_write(REG_NET_WIDTH, 16'd0);
      csr_write(REG_NET_HEIGHT, 16'h07ff);
      csr_write(REG_IMAGE_WIDTH, 16'h3fff);
      csr_write(REG_IMAGE_HEIGHT, 16'h3fff);
      csr_write(REG_LAYOUT_MODE, 16'hffff);
      for (int i = 0; i < 6; i++) begin
         d = '{16'hffff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff};
         if (i[0]) d.delta_x = 16'h8000;
         send_anchor(d);
      end
      go_idle();
      csr_write(REG_IMAGE_WIDTH, 16'd0);
      csr_write(REG_IMAGE_HEIGHT, 16'd0);
      csr_write(REG_THRESHOLD, 16'hffff);
      d = '{16'hffff, 16'h1234, 16'h4321, 16'h0100, 16'hff00};    send_anchor(d);
      go_idle();
      csr_write(REG_THRESHOLD, 16'hfffe);
      send_anchor(d);
      d.anchor_score = 16'hfffe;
      send_anchor(d);
      go_idle();

      // random phases, each with its own settings
      for (int ph = 0; ph < PHASES; ph++) begin
         csr_write(REG_LAYOUT_MODE, 16'($urandom_range(1)));
         csr_write(REG_NET_WIDTH, pick_net());
         csr_write(REG_NET_HEIGHT, pick_net());
         csr_write(REG_IMAGE_WIDTH, pick_image());
         csr_write(REG_IMAGE_HEIGHT, pick_image());
         csr_write(REG_THRESHOLD, (ph == 0) ? 16'd0 : 16'($urandom));
         quiet = (ph == 3);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 5 && i == 10) long_hold = 1;   // block fills and stalls input
            send_anchor(random_anchor());
         end
         go_idle();
      end
      quiet = 0;
      repeat (20) @(posedge clock);

      $display("%0d anchors sent over %0d settings, %0d kept, %0d full frames",
               items_sent, PHASES + 4, kept_count, frame_count);
      $display("covered reset and extreme settings, stale counters, long output stall");
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, pending);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
